// ===== rtl/psf_pkg.sv =====
// Shared types, register indexes and fixed point helpers of the pore slab force block.
// Used by psf_isqrt, psf_div and pore_slab_force; depends on nothing.
package psf_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS   = 3'd0,
    CFG_PORE_RADIUS = 3'd1,
    CFG_HALF_THICK  = 3'd2,
    CFG_CENTER_X    = 3'd3,
    CFG_CENTER_Y    = 3'd4,
    CFG_CENTER_Z    = 3'd5,
    CFG_AXIS        = 3'd6
  } psf_cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } psf_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic        [30:0] energy;
  } psf_out_t;

  // Side data that rides along the square root pipeline.
  typedef struct packed {
    logic               vld;
    logic               zero;
    logic               far;
    logic               zneg;
    logic        [30:0] dplane;
    logic signed [33:0] rp_x;
    logic signed [33:0] rp_y;
    logic signed [33:0] rp_z;
  } psf_sq_side_t;

  // Side data that rides along the divider pipeline.
  typedef struct packed {
    logic               vld;
    logic               zero;
    logic               radial;
    logic signed [33:0] rp_x;
    logic signed [33:0] rp_y;
    logic signed [33:0] rp_z;
    logic signed [31:0] ff_x;
    logic signed [31:0] ff_y;
    logic signed [31:0] ff_z;
    logic        [30:0] energy;
  } psf_dv_side_t;

  // Arithmetic right shift by n with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                 input int unsigned n);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + (64'd1 << (n - 1))) >> n;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/pore_slab_force.sv =====
// Top level of the pore slab force block: config registers and the main force pipeline.
// Depends on psf_pkg, psf_isqrt and psf_div.
//
// pore_slab_force takes one particle position per request and returns one result: the
// restoring force (three signed Q16.16 components) and the energy (unsigned Q16.16) of a
// slab membrane pierced by a cylindrical pore. The block is a single pipeline that accepts
// a new request in every cycle unless stalled. Its depth is set by the 32-stage square root
// that finds the radial distance and by the 31-stage divider that forms the radial force
// factor; the remaining stages hold one multiplier rank or one wide add each. When
// out_stall holds a finished result, the whole pipeline freezes and in_stall rises, so
// nothing is lost or repeated. Configuration is written through the cfg port (always
// ready); the user must write it only while no request is in flight; the block does not
// enforce this. The axis is used as written and must already be normalized by software.
module pore_slab_force (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  psf_pkg::psf_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output psf_pkg::psf_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import psf_pkg::*;

  // Configuration registers.
  logic [30:0]        stiffness_r;
  logic [30:0]        pore_radius_r;
  logic [30:0]        half_thick_r;
  logic signed [31:0] center_r [3];
  logic [47:0]        axis_r;
  logic signed [15:0] ax [3];

  // The pipeline advances whenever the output register is free or being taken.
  logic adv;
  logic out_valid_r;
  psf_out_t out_data_r;

  // Front stages: offset, axial projection, perpendicular part.
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [32:0] r1_r [3];
  logic signed [32:0] r2_r [3];
  logic signed [32:0] r3_r [3];
  logic signed [32:0] r4_r [3];
  logic signed [32:0] r5_r [3];
  logic signed [48:0] p2_r [3];
  logic signed [50:0] s3_r;
  logic signed [63:0] z4_nxt;
  logic [63:0]        absz4_nxt;
  logic signed [31:0] z4_r;
  logic [30:0]        absz4_r;
  logic               out4_r, zneg4_r;
  logic signed [47:0] q5_r [3];
  logic [30:0]        dpl5_r;
  logic               out5_r, zneg5_r;
  psf_sq_side_t       sd6_r, sd7_r, sd8_r, sd9_r;
  psf_sq_side_t       sd7_nxt, sd9_nxt;
  logic [31:0]        mag7_r [3];
  logic [63:0]        sq8_r  [3];
  logic [63:0]        rad9_r;
  logic [65:0]        sum9_nxt;
  logic [33:0]        mag7_nxt [3];
  logic signed [33:0] rp6_nxt [3];

  // Square root output and branch stages.
  logic [31:0]        rho_w;
  psf_sq_side_t       sq_out;
  psf_sq_side_t       sa_r, sb_r, sc_r, sdd_r;
  psf_sq_side_t       sa_nxt;
  logic               a_radial_r, b_radial_r, c_radial_r, d_radial_r;
  logic [31:0]        a_rho_r, b_rho_r, c_rho_r, d_rho_r, e_rho_r;
  logic [30:0]        a_d_r;
  logic signed [32:0] a_diff_nxt;
  logic               a_inpore_nxt, a_radial_nxt;
  logic [61:0]        b_kd_r, c_kd_r, d_kd_r, e_kd_r;
  logic [61:0]        b_dd_r;
  logic [45:0]        c_m_r, c_d2_r;
  logic signed [63:0] d_mf_r [3];
  logic [53:0]        d_elo_r, d_ehi_r;
  logic [77:0]        e_sum_nxt;
  logic signed [31:0] e_ff_nxt [3];
  psf_dv_side_t       e_side_r;

  // Divider output and final stages.
  logic [30:0]        fac_w;
  psf_dv_side_t       dv_out;
  psf_dv_side_t       g_side_r;
  logic signed [63:0] g_prod_r [3];
  logic signed [31:0] h_fr_nxt [3];

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ax[0] = $signed(axis_r[47:32]);
  assign ax[1] = $signed(axis_r[31:16]);
  assign ax[2] = $signed(axis_r[15:0]);

  // Register writes. An index past the end of the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r   <= 31'd65536;
      pore_radius_r <= 31'd65536;
      half_thick_r  <= 31'd32768;
      center_r[0]   <= '0;
      center_r[1]   <= '0;
      center_r[2]   <= '0;
      axis_r        <= 48'd32767;
    end else if (cfg_valid && cfg_ready) begin
      unique case (psf_cfg_idx_t'(cfg_index))
        CFG_STIFFNESS:   stiffness_r   <= cfg_data[30:0];
        CFG_PORE_RADIUS: pore_radius_r <= cfg_data[30:0];
        CFG_HALF_THICK:  half_thick_r  <= cfg_data[30:0];
        CFG_CENTER_X:    center_r[0]   <= $signed(cfg_data[31:0]);
        CFG_CENTER_Y:    center_r[1]   <= $signed(cfg_data[31:0]);
        CFG_CENTER_Z:    center_r[2]   <= $signed(cfg_data[31:0]);
        CFG_AXIS:        axis_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Combinational parts of the stages that need more than one line.
  always_comb begin
    // Axial coordinate, rounded back to Q16.16.
    z4_nxt    = rnd_shr(64'(s3_r), 15);
    absz4_nxt = z4_nxt[63] ? 64'(-z4_nxt) : 64'(z4_nxt);
    // Perpendicular part of the offset.
    for (int i = 0; i < 3; i++) begin
      rp6_nxt[i]  = 34'(r5_r[i]) - 34'(rnd_shr(64'(q5_r[i]), 15));
    end
    mag7_nxt[0] = sd6_r.rp_x[33] ? 34'(-sd6_r.rp_x) : 34'(sd6_r.rp_x);
    mag7_nxt[1] = sd6_r.rp_y[33] ? 34'(-sd6_r.rp_y) : 34'(sd6_r.rp_y);
    mag7_nxt[2] = sd6_r.rp_z[33] ? 34'(-sd6_r.rp_z) : 34'(sd6_r.rp_z);
    // A component at or past 2^32 forces the face branch.
    sd7_nxt     = sd6_r;
    sd7_nxt.far = (mag7_nxt[0][33:32] != 2'b00) || (mag7_nxt[1][33:32] != 2'b00) ||
                  (mag7_nxt[2][33:32] != 2'b00);
    sum9_nxt    = 66'(sq8_r[0]) + 66'(sq8_r[1]) + 66'(sq8_r[2]);
    // Overflow of 64 bits in the sum of squares also means far.
    sd9_nxt     = sd8_r;
    sd9_nxt.far = sd8_r.far || (sum9_nxt[65:64] != 2'b00);
    // Branch choice: radial penetration wins only if strictly smaller than the face one.
    a_diff_nxt   = $signed({1'b0, rho_w}) - $signed({2'b0, pore_radius_r});
    a_inpore_nxt = (rho_w <= {1'b0, pore_radius_r});
    a_radial_nxt = !sq_out.far && !a_inpore_nxt &&
                   (a_diff_nxt < $signed({2'b0, sq_out.dplane}));
    sa_nxt       = sq_out;
    sa_nxt.zero  = sq_out.zero || (!sq_out.far && a_inpore_nxt);
    // Energy: saturation happens exactly when the rounded sum reaches 2^48.
    e_sum_nxt = 78'(d_elo_r) + (78'(d_ehi_r) << 23) + 78'd65536;
    for (int i = 0; i < 3; i++) begin
      e_ff_nxt[i] = sat32(sdd_r.zneg ? -rnd_shr(d_mf_r[i], 15) : rnd_shr(d_mf_r[i], 15));
      h_fr_nxt[i] = sat32(-rnd_shr(g_prod_r[i], 16));
    end
  end

  // Main pipeline. Only valid bits are reset; payload follows them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      sd6_r.vld   <= 1'b0;
      sd7_r.vld   <= 1'b0;
      sd8_r.vld   <= 1'b0;
      sd9_r.vld   <= 1'b0;
      sa_r.vld    <= 1'b0;
      sb_r.vld    <= 1'b0;
      sc_r.vld    <= 1'b0;
      sdd_r.vld   <= 1'b0;
      e_side_r.vld <= 1'b0;
      g_side_r.vld <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      // Stage 1: offset from the pore center.
      v1_r    <= in_valid;
      r1_r[0] <= 33'(in_data.pos_x) - 33'(center_r[0]);
      r1_r[1] <= 33'(in_data.pos_y) - 33'(center_r[1]);
      r1_r[2] <= 33'(in_data.pos_z) - 33'(center_r[2]);
      // Stage 2: products with the axis.
      v2_r <= v1_r;
      for (int i = 0; i < 3; i++) begin
        p2_r[i] <= r1_r[i] * ax[i];
        r2_r[i] <= r1_r[i];
      end
      // Stage 3: dot product.
      v3_r <= v2_r;
      s3_r <= 51'(p2_r[0]) + 51'(p2_r[1]) + 51'(p2_r[2]);
      r3_r <= r2_r;
      // Stage 4: rounding and slab test.
      v4_r    <= v3_r;
      z4_r    <= z4_nxt[31:0];
      absz4_r <= absz4_nxt[30:0];
      out4_r  <= (absz4_nxt >= 64'(half_thick_r));
      zneg4_r <= z4_nxt[63];
      r4_r    <= r3_r;
      // Stage 5: axial part projected back on the axis.
      v5_r    <= v4_r;
      for (int i = 0; i < 3; i++) begin
        q5_r[i] <= z4_r * ax[i];
      end
      dpl5_r  <= half_thick_r - absz4_r;
      out5_r  <= out4_r;
      zneg5_r <= zneg4_r;
      r5_r    <= r4_r;
      // Stage 6: perpendicular vector.
      sd6_r.vld    <= v5_r;
      sd6_r.zero   <= out5_r;
      sd6_r.far    <= 1'b0;
      sd6_r.zneg   <= zneg5_r;
      sd6_r.dplane <= dpl5_r;
      sd6_r.rp_x   <= rp6_nxt[0];
      sd6_r.rp_y   <= rp6_nxt[1];
      sd6_r.rp_z   <= rp6_nxt[2];
      // Stage 7: magnitudes and the far flag.
      sd7_r <= sd7_nxt;
      for (int i = 0; i < 3; i++) begin
        mag7_r[i] <= mag7_nxt[i][31:0];
      end
      // Stage 8: squares.
      sd8_r <= sd7_r;
      for (int i = 0; i < 3; i++) begin
        sq8_r[i] <= mag7_r[i] * mag7_r[i];
      end
      // Stage 9: sum of squares.
      sd9_r     <= sd9_nxt;
      rad9_r    <= sum9_nxt[63:0];
      // Stage A: pore test and branch choice.
      sa_r       <= sa_nxt;
      a_radial_r <= a_radial_nxt;
      a_d_r      <= a_radial_nxt ? a_diff_nxt[30:0] : sq_out.dplane;
      a_rho_r    <= rho_w;
      // Stage B: stiffness times penetration, penetration squared.
      sb_r       <= sa_r;
      b_radial_r <= a_radial_r;
      b_rho_r    <= a_rho_r;
      b_kd_r     <= stiffness_r * a_d_r;
      b_dd_r     <= a_d_r * a_d_r;
      // Stage C: rounded face magnitude and d squared.
      sc_r       <= sb_r;
      c_radial_r <= b_radial_r;
      c_rho_r    <= b_rho_r;
      c_kd_r     <= b_kd_r;
      c_m_r      <= 46'((b_kd_r + 62'd32768) >> 16);
      c_d2_r     <= 46'((b_dd_r + 62'd32768) >> 16);
      // Stage D: face force products and energy partial products.
      sdd_r      <= sc_r;
      d_radial_r <= c_radial_r;
      d_rho_r    <= c_rho_r;
      d_kd_r     <= c_kd_r;
      for (int i = 0; i < 3; i++) begin
        d_mf_r[i] <= $signed({1'b0, c_m_r}) * ax[i];
      end
      d_elo_r <= stiffness_r * c_d2_r[22:0];
      d_ehi_r <= stiffness_r * c_d2_r[45:23];
      // Stage E: face forces and energy are final; radial factor goes to the divider.
      e_side_r.vld    <= sdd_r.vld;
      e_side_r.zero   <= sdd_r.zero;
      e_side_r.radial <= d_radial_r;
      e_side_r.rp_x   <= sdd_r.rp_x;
      e_side_r.rp_y   <= sdd_r.rp_y;
      e_side_r.rp_z   <= sdd_r.rp_z;
      e_side_r.ff_x   <= e_ff_nxt[0];
      e_side_r.ff_y   <= e_ff_nxt[1];
      e_side_r.ff_z   <= e_ff_nxt[2];
      e_side_r.energy <= (e_sum_nxt[77:48] != '0) ? 31'h7FFFFFFF : e_sum_nxt[47:17];
      e_kd_r          <= d_kd_r;
      e_rho_r         <= d_rho_r;
      // Stage G: radial factor times the perpendicular vector.
      g_side_r    <= dv_out;
      g_prod_r[0] <= $signed({1'b0, fac_w}) * dv_out.rp_x;
      g_prod_r[1] <= $signed({1'b0, fac_w}) * dv_out.rp_y;
      g_prod_r[2] <= $signed({1'b0, fac_w}) * dv_out.rp_z;
      // Stage H: pick the branch and load the output register.
      out_valid_r <= g_side_r.vld;
      if (g_side_r.zero) begin
        out_data_r <= '0;
      end else if (g_side_r.radial) begin
        out_data_r.force_x <= h_fr_nxt[0];
        out_data_r.force_y <= h_fr_nxt[1];
        out_data_r.force_z <= h_fr_nxt[2];
        out_data_r.energy  <= g_side_r.energy;
      end else begin
        out_data_r.force_x <= g_side_r.ff_x;
        out_data_r.force_y <= g_side_r.ff_y;
        out_data_r.force_z <= g_side_r.ff_z;
        out_data_r.energy  <= g_side_r.energy;
      end
    end
  end

  psf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .radicand (rad9_r),
    .in_side  (sd9_r),
    .root     (rho_w),
    .out_side (sq_out)
  );

  psf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .dividend (e_kd_r),
    .divisor  (e_rho_r),
    .in_side  (e_side_r),
    .quot     (fac_w),
    .out_side (dv_out)
  );

`ifndef SYNTHESIS
  // The input side is held back only by a result that waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("in_stall raised without a stalled result");

  // A stalled result freezes the front of the pipeline.
  a_front_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(v1_r) && $stable(sd9_r.vld)))
    else $error("pipeline moved while the output was stalled");

  // The radial branch is chosen only outside the pore radius.
  a_radial_rho: assert property (@(posedge clk) disable iff (!rst_n)
    (sa_r.vld && !sa_r.zero && a_radial_r) |-> (a_rho_r > {1'b0, pore_radius_r}))
    else $error("radial branch inside the pore");
`endif

endmodule

// ===== rtl/psf_isqrt.sv =====
// Fully pipelined integer square root, one result bit per stage, 32 stages.
// Depends on psf_pkg for the side data type.
module psf_isqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [63:0]          radicand,
  input  psf_pkg::psf_sq_side_t in_side,
  output logic [31:0]          root,
  output psf_pkg::psf_sq_side_t out_side
);
  import psf_pkg::*;

  localparam int STAGES = 32;

  logic [63:0]  v_r    [1:STAGES];
  logic [63:0]  res_r  [1:STAGES];
  psf_sq_side_t sd_r   [1:STAGES];
  logic [63:0]  v_nxt  [1:STAGES];
  logic [63:0]  res_nxt[1:STAGES];
  psf_sq_side_t sd_nxt [1:STAGES];
  logic [63:0]  v_c    [0:STAGES-1];
  logic [63:0]  res_c  [0:STAGES-1];
  psf_sq_side_t sd_c   [0:STAGES-1];

  always_comb begin
    logic [63:0] bm;
    logic [63:0] t;
    v_c[0]   = radicand;
    res_c[0] = '0;
    sd_c[0]  = in_side;
    for (int j = 1; j < STAGES; j++) begin
      v_c[j]   = v_r[j];
      res_c[j] = res_r[j];
      sd_c[j]  = sd_r[j];
    end
    for (int j = 0; j < STAGES; j++) begin
      bm = 64'd1 << (7'(62 - 2 * j));
      t  = res_c[j] + bm;
      if (v_c[j] >= t) begin
        v_nxt[j+1]   = v_c[j] - t;
        res_nxt[j+1] = (res_c[j] >> 1) + bm;
      end else begin
        v_nxt[j+1]   = v_c[j];
        res_nxt[j+1] = res_c[j] >> 1;
      end
      sd_nxt[j+1] = sd_c[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= STAGES; k++) begin
        sd_r[k].vld <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 1; k <= STAGES; k++) begin
        v_r[k]   <= v_nxt[k];
        res_r[k] <= res_nxt[k];
        sd_r[k]  <= sd_nxt[k];
      end
    end
  end

  assign root     = res_r[STAGES][31:0];
  assign out_side = sd_r[STAGES];

endmodule

// ===== rtl/psf_div.sv =====
// Fully pipelined restoring divider, one quotient bit per stage, 31 stages.
// Depends on psf_pkg; the quotient must be known to fit in 31 bits.
module psf_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [61:0]          dividend,
  input  logic [31:0]          divisor,
  input  psf_pkg::psf_dv_side_t in_side,
  output logic [30:0]          quot,
  output psf_pkg::psf_dv_side_t out_side
);
  import psf_pkg::*;

  localparam int STAGES = 31;

  logic [31:0]  rem_r  [1:STAGES];
  logic [30:0]  q_r    [1:STAGES];
  logic [30:0]  lo_r   [1:STAGES];
  logic [31:0]  dvs_r  [1:STAGES];
  psf_dv_side_t sd_r   [1:STAGES];
  logic [31:0]  rem_nxt[1:STAGES];
  logic [30:0]  q_nxt  [1:STAGES];
  logic [30:0]  lo_nxt [1:STAGES];
  logic [31:0]  dvs_nxt[1:STAGES];
  psf_dv_side_t sd_nxt [1:STAGES];
  logic [31:0]  rem_c  [0:STAGES-1];
  logic [30:0]  q_c    [0:STAGES-1];
  logic [30:0]  lo_c   [0:STAGES-1];
  logic [31:0]  dvs_c  [0:STAGES-1];
  psf_dv_side_t sd_c   [0:STAGES-1];

  always_comb begin
    logic [32:0] t;
    logic        ge;
    rem_c[0] = {1'b0, dividend[61:31]};
    q_c[0]   = '0;
    lo_c[0]  = dividend[30:0];
    dvs_c[0] = divisor;
    sd_c[0]  = in_side;
    for (int j = 1; j < STAGES; j++) begin
      rem_c[j] = rem_r[j];
      q_c[j]   = q_r[j];
      lo_c[j]  = lo_r[j];
      dvs_c[j] = dvs_r[j];
      sd_c[j]  = sd_r[j];
    end
    for (int j = 0; j < STAGES; j++) begin
      t  = {rem_c[j], lo_c[j][STAGES-1-j]};
      ge = (t >= {1'b0, dvs_c[j]});
      rem_nxt[j+1] = ge ? 32'(t - {1'b0, dvs_c[j]}) : t[31:0];
      q_nxt[j+1]   = q_c[j];
      q_nxt[j+1][STAGES-1-j] = ge;
      lo_nxt[j+1]  = lo_c[j];
      dvs_nxt[j+1] = dvs_c[j];
      sd_nxt[j+1]  = sd_c[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= STAGES; k++) begin
        sd_r[k].vld <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 1; k <= STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        dvs_r[k] <= dvs_nxt[k];
        sd_r[k]  <= sd_nxt[k];
      end
    end
  end

  assign quot     = q_r[STAGES];
  assign out_side = sd_r[STAGES];

endmodule
